FILE: rtl/tws_pkg.sv
// Package for the timing wheel scheduler: item kinds, result codes and the
// command record passed from the front end to the back end. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package tws_pkg;

  typedef enum logic [1:0] {
    KIND_ADD    = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_TICK   = 2'd2,
    KIND_NONE   = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_ADDED    = 3'd0,
    ST_REJECTED = 3'd1,
    ST_REMOVED  = 3'd2,
    ST_EXPIRED  = 3'd3,
    ST_DONE     = 3'd4
  } status_e;

  localparam int unsigned DelayW  = 24;
  localparam int unsigned PeriodW = 16;
  localparam int unsigned IdW     = 5;
  localparam int unsigned TickW   = 32;
  localparam logic [PeriodW-1:0] PeriodReset = 16'd10;

  // One classified command; quotient and ceiling flag come from the divider.
  typedef struct packed {
    kind_e              kind;
    logic [IdW-1:0]     id;
    logic [DelayW-1:0]  whole;
    logic               round_up;
    logic               neg;
  } cmd_t;

endpackage
`default_nettype wire

FILE: rtl/tws_front.sv
// Front end: accepts items, divides add delays by the tick period
// (one quotient bit per cycle) and pushes commands into a small queue.
// Depends on tws_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tws_front (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        push,
  output logic                             full,
  input  wire logic [1:0]                  kind_i,
  input  wire logic [tws_pkg::IdW-1:0]     timer_id_i,
  input  wire logic [tws_pkg::DelayW-1:0]  delay_ms_i,
  input  wire logic [tws_pkg::PeriodW-1:0] period_i,
  output logic                             cmd_valid_o,
  input  wire logic                        cmd_ready_i,
  output tws_pkg::cmd_t                    cmd_o
);

  localparam int unsigned CntW = $clog2(tws_pkg::DelayW + 1);

  logic                        div_q, div_d;
  logic [CntW-1:0]             cnt_q;
  logic [tws_pkg::DelayW-1:0]  quo_q;
  logic [tws_pkg::PeriodW:0]   rem_q;
  logic [tws_pkg::PeriodW-1:0] div_by_q;
  logic [tws_pkg::IdW-1:0]     id_q;

  // two-entry queue
  tws_pkg::cmd_t fifo_q [2];
  logic          wr_q, rd_q;
  logic [1:0]    cnt_f_q;
  logic          enq;
  tws_pkg::cmd_t enq_cmd;
  logic          acc;
  logic [tws_pkg::PeriodW:0] trial;
  logic          fin;

  assign full  = div_q || (cnt_f_q == 2'd2);
  assign acc   = push && !full;

  assign trial = {rem_q[tws_pkg::PeriodW-1:0], quo_q[tws_pkg::DelayW-1]};
  assign fin   = div_q && (cnt_q == CntW'(1));

  always_comb begin
    enq = 1'b0;
    enq_cmd = '0;
    enq_cmd.kind = tws_pkg::kind_e'(kind_i);
    enq_cmd.id   = timer_id_i;
    enq_cmd.neg  = delay_ms_i[tws_pkg::DelayW-1];
    div_d = div_q;
    if (div_q) begin
      if (fin) begin
        div_d = 1'b0;
        enq = 1'b1;
        enq_cmd.kind = tws_pkg::KIND_ADD;
        enq_cmd.id = id_q;
        enq_cmd.neg = 1'b0;
        enq_cmd.whole = {quo_q[tws_pkg::DelayW-2:0], (trial >= {1'b0, div_by_q})};
        enq_cmd.round_up = ((trial >= {1'b0, div_by_q}) ? (trial - {1'b0, div_by_q})
                           : trial) != '0;
      end
    end else if (acc) begin
      if (kind_i == tws_pkg::KIND_ADD && !delay_ms_i[tws_pkg::DelayW-1]) begin
        div_d = 1'b1;
      end else if (kind_i != tws_pkg::KIND_NONE) begin
        enq = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      div_q <= div_d;
      if (!div_q && div_d) cnt_q <= CntW'(tws_pkg::DelayW);
      else if (div_q) cnt_q <= cnt_q - CntW'(1);
    end
  end

  // restoring division, one quotient bit per cycle
  always_ff @(posedge clk_i) begin
    if (!div_q && div_d) begin
      quo_q    <= delay_ms_i;
      rem_q    <= '0;
      div_by_q <= (period_i == '0) ? tws_pkg::PeriodW'(1) : period_i;
      id_q     <= timer_id_i;
    end else if (div_q) begin
      if (trial >= {1'b0, div_by_q}) begin
        rem_q <= trial - {1'b0, div_by_q};
        quo_q <= {quo_q[tws_pkg::DelayW-2:0], 1'b1};
      end else begin
        rem_q <= trial;
        quo_q <= {quo_q[tws_pkg::DelayW-2:0], 1'b0};
      end
    end
  end

  logic deq;
  assign cmd_valid_o = cnt_f_q != 2'd0;
  assign cmd_o = fifo_q[rd_q];
  assign deq = cmd_valid_o && cmd_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= 1'b0;
      rd_q <= 1'b0;
      cnt_f_q <= '0;
    end else begin
      if (enq) wr_q <= ~wr_q;
      if (deq) rd_q <= ~rd_q;
      cnt_f_q <= cnt_f_q + {1'b0, enq} - {1'b0, deq};
    end
  end

  always_ff @(posedge clk_i) begin
    if (enq) fifo_q[wr_q] <= enq_cmd;
  end

endmodule
`default_nettype wire

FILE: rtl/tws_back.sv
// Back end: timer table, wheel pointer, tick counter. Depends on tws_pkg.
// Runs commands; a tick scans one entry per cycle while the output is free.
`timescale 1ns / 1ps
`default_nettype none
module tws_back #(
  parameter int unsigned WHEEL_SLOTS = 64,
  parameter int unsigned MAX_TIMERS  = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     cmd_valid_i,
  output logic                          cmd_ready_o,
  input  wire tws_pkg::cmd_t            cmd_i,
  output logic                          res_valid_o,
  input  wire logic                     res_ready_i,
  output tws_pkg::status_e              res_status_o,
  output logic [tws_pkg::IdW-1:0]       res_id_o,
  output logic                          res_last_o
);

  localparam int unsigned SlotW = (WHEEL_SLOTS > 1) ? $clog2(WHEEL_SLOTS) : 1;
  localparam int unsigned TIdxW = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
  localparam int unsigned IdxW  = $clog2(MAX_TIMERS + 1);

  logic [MAX_TIMERS-1:0]    active_q;
  logic [SlotW-1:0]         slot_q [MAX_TIMERS];
  logic [tws_pkg::TickW-1:0] due_q [MAX_TIMERS];
  logic [SlotW-1:0]         ptr_q;
  logic [tws_pkg::TickW-1:0] ticks_q;
  logic                     scan_q;
  logic [IdxW-1:0]          idx_q;

  // result register
  logic                     rv_q;
  tws_pkg::status_e         rs_q;
  logic [tws_pkg::IdW-1:0]  rid_q;
  logic                     rl_q;

  assign res_valid_o  = rv_q;
  assign res_status_o = rs_q;
  assign res_id_o     = rid_q;
  assign res_last_o   = rl_q;

  logic out_free;
  assign out_free    = !rv_q || res_ready_i;
  assign cmd_ready_o = !scan_q && out_free;

  logic take;
  assign take = cmd_valid_i && cmd_ready_o;

  logic            id_ok;
  logic [TIdxW-1:0] cid;
  assign id_ok = {{(32-tws_pkg::IdW){1'b0}}, cmd_i.id} < MAX_TIMERS;
  assign cid   = TIdxW'(cmd_i.id);

  logic [TIdxW-1:0] sid;
  logic             hit;
  logic [tws_pkg::TickW-1:0] diff;
  assign sid  = TIdxW'(idx_q);
  assign diff = ticks_q - due_q[sid];
  assign hit  = active_q[sid] && slot_q[sid] == ptr_q && !diff[tws_pkg::TickW-1];

  logic [SlotW-1:0] add_slot;
  logic [SlotW+tws_pkg::DelayW:0] slot_sum;
  assign slot_sum = {{(tws_pkg::DelayW+1){1'b0}}, ptr_q}
                  + {{(SlotW+1){1'b0}}, cmd_i.whole};
  assign add_slot = SlotW'(slot_sum % WHEEL_SLOTS);

  logic [SlotW-1:0] ptr_next;
  assign ptr_next = (ptr_q == SlotW'(WHEEL_SLOTS - 1)) ? '0 : ptr_q + SlotW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= '0;
      ptr_q    <= '0;
      ticks_q  <= '0;
      scan_q   <= 1'b0;
      idx_q    <= '0;
      rv_q     <= 1'b0;
    end else begin
      if (res_ready_i) rv_q <= 1'b0;
      if (scan_q && out_free) begin
        if (idx_q == IdxW'(MAX_TIMERS)) begin
          rv_q   <= 1'b1;
          scan_q <= 1'b0;
          ptr_q  <= ptr_next;
        end else begin
          if (hit) begin
            active_q[sid] <= 1'b0;
            rv_q <= 1'b1;
          end
          idx_q <= idx_q + IdxW'(1);
        end
      end else if (take) begin
        rv_q <= 1'b1;
        unique case (cmd_i.kind)
          tws_pkg::KIND_ADD: begin
            if (!cmd_i.neg && id_ok && !active_q[cid]) active_q[cid] <= 1'b1;
          end
          tws_pkg::KIND_REMOVE: begin
            if (id_ok) active_q[cid] <= 1'b0;
          end
          tws_pkg::KIND_TICK: begin
            ticks_q <= ticks_q + 32'd1;
            scan_q  <= 1'b1;
            idx_q   <= '0;
            rv_q    <= 1'b0;
          end
          default: rv_q <= 1'b0;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (scan_q && out_free) begin
      if (idx_q == IdxW'(MAX_TIMERS)) begin
        rs_q <= tws_pkg::ST_DONE; rid_q <= '0; rl_q <= 1'b1;
      end else begin
        rs_q <= tws_pkg::ST_EXPIRED; rid_q <= tws_pkg::IdW'(idx_q); rl_q <= 1'b0;
      end
    end else if (take) begin
      rid_q <= '0;
      rl_q  <= 1'b1;
      if (cmd_i.kind == tws_pkg::KIND_ADD) begin
        if (cmd_i.neg || !id_ok || active_q[cid]) begin
          rs_q <= tws_pkg::ST_REJECTED;
        end else begin
          rs_q <= tws_pkg::ST_ADDED;
          slot_q[cid] <= add_slot;
          due_q[cid]  <= ticks_q + tws_pkg::TickW'(cmd_i.whole)
                       + {31'd0, cmd_i.round_up};
        end
      end else begin
        rs_q <= tws_pkg::ST_REMOVED;
      end
    end
  end

endmodule
`default_nettype wire

FILE: rtl/timing_wheel_scheduler.sv
// Timing wheel scheduler top: tws_front, tws_back and the tick period register.
// An add is divided in the front end, then queued; the front end accepts no
// new item while it divides. A tick scans every timer entry, then gives the
// done beat; no command is taken during the scan. An unpopped result holds
// back the ones behind it.
// Async active-low reset clears timers, pointer and tick count; period is 10 ms.
`timescale 1ns / 1ps
`default_nettype none
module timing_wheel_scheduler #(
  parameter int unsigned WHEEL_SLOTS = 64,
  parameter int unsigned MAX_TIMERS  = 32
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        push,
  output logic                             full,
  input  wire logic [1:0]                  kind_i,
  input  wire logic [tws_pkg::IdW-1:0]     timer_id_i,
  input  wire logic signed [tws_pkg::DelayW-1:0] delay_ms_i,
  output logic                             empty,
  input  wire logic                        pop,
  output logic [2:0]                       status_o,
  output logic [tws_pkg::IdW-1:0]          expired_id_o,
  output logic                             last_o,
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic [tws_pkg::PeriodW-1:0] cfg_data_i
);

  logic [tws_pkg::PeriodW-1:0] period_q;
  logic                        cmd_valid, cmd_ready;
  tws_pkg::cmd_t               cmd;
  logic                        res_valid;
  tws_pkg::status_e            res_status;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) period_q <= tws_pkg::PeriodReset;
    else if (cfg_valid_i && cfg_ready_o) period_q <= cfg_data_i;
  end

  tws_front u_front (
    .clk_i, .rst_ni, .push, .full, .kind_i, .timer_id_i,
    .delay_ms_i  (delay_ms_i),
    .period_i    (period_q),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  tws_back #(.WHEEL_SLOTS(WHEEL_SLOTS), .MAX_TIMERS(MAX_TIMERS)) u_back (
    .clk_i, .rst_ni,
    .cmd_valid_i  (cmd_valid),
    .cmd_ready_o  (cmd_ready),
    .cmd_i        (cmd),
    .res_valid_o  (res_valid),
    .res_ready_i  (pop),
    .res_status_o (res_status),
    .res_id_o     (expired_id_o),
    .res_last_o   (last_o)
  );

  assign empty    = !res_valid;
  assign status_o = res_status;

endmodule
`default_nettype wire

FILE: rtl/tws_checker.sv
// Port-level checks for the timing wheel scheduler, bound to the top level.
// Depends on tws_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tws_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       empty,
  input wire logic       pop,
  input wire logic [2:0] status_o,
  input wire logic [4:0] expired_id_o,
  input wire logic       last_o
);
  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && status_o == tws_pkg::ST_DONE |-> last_o) else $error("done without last");
  a_exp_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && status_o == tws_pkg::ST_EXPIRED |-> !last_o) else $error("expired marked last");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(status_o)) else $error("result dropped");
  a_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> status_o <= 3'd4) else $error("bad status");
  a_id_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && status_o != tws_pkg::ST_EXPIRED |-> expired_id_o == '0) else $error("stray id");
endmodule

bind timing_wheel_scheduler tws_checker u_tws_checker (
  .clk_i, .rst_ni, .empty, .pop, .status_o, .expired_id_o, .last_o
);
`default_nettype wire

FILE: dv/timing_wheel_scheduler_test.sv
// Self-checking bench for timing_wheel_scheduler: adds, removes and ticks go in
// through the push/full queue port, and every result is checked against an
// in-bench wheel predictor. Depends on tws_pkg and the scheduler RTL.
`timescale 1ns / 1ps
module timing_wheel_scheduler_test;

  localparam int unsigned Slots = 64;
  localparam int unsigned Timers = 32;
  localparam int unsigned CycleLimit = 400000;

  typedef struct packed {
    logic [1:0]  kind;
    logic [4:0]  id;
    logic [23:0] delay;
  } req_t;

  typedef struct packed {
    logic [2:0] status;
    logic [4:0] id;
    logic       last;
  } rsp_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic full;
  logic [1:0] kind_i = '0;
  logic [4:0] timer_id_i = '0;
  logic signed [23:0] delay_ms_i = '0;
  logic empty;
  logic pop = 1'b0;
  logic [2:0] status_o;
  logic [4:0] expired_id_o;
  logic last_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [15:0] cfg_data_i = '0;

  timing_wheel_scheduler u_top (
    .clk_i(clk_i), .rst_ni(rst_ni), .push(push), .full(full),
    .kind_i(kind_i), .timer_id_i(timer_id_i), .delay_ms_i(delay_ms_i),
    .empty(empty), .pop(pop), .status_o(status_o), .expired_id_o(expired_id_o),
    .last_o(last_o), .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o),
    .cfg_data_i(cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  // predictor state
  logic [15:0] period_ms = tws_pkg::PeriodReset;
  logic        active[Timers];
  logic [5:0]  slot_of[Timers];
  logic [31:0] due_of[Timers];
  logic [5:0]  wheel_ptr = '0;
  logic [31:0] ticks = '0;

  req_t pending_reqs[$];
  rsp_t expected_rsps[$];
  int   errors = 0;
  int   cycles = 0;
  bit   quiet = 1'b0;      // no idling in the closing stretch
  bit   hold_pop = 1'b0;   // long receiver hold-off
  int   phase = -1;
  int   send_gap = 0;
  int   recv_gap = 0;

  function automatic void predict_wheel(req_t r);
    logic [15:0] p;
    logic [23:0] whole;
    logic [31:0] lag;
    rsp_t e;
    p = (period_ms == 16'd0) ? 16'd1 : period_ms;
    e = '0;
    e.last = 1'b1;
    case (r.kind)
      tws_pkg::KIND_ADD: begin
        if (r.delay[23] || active[r.id]) begin
          e.status = tws_pkg::ST_REJECTED;
        end else begin
          whole = r.delay / p;
          slot_of[r.id] = 6'((32'(wheel_ptr) + 32'(whole)) % Slots);
          due_of[r.id] = ticks + 32'(whole) + 32'((r.delay % p) != 24'd0);
          active[r.id] = 1'b1;
          e.status = tws_pkg::ST_ADDED;
        end
        expected_rsps.push_back(e);
      end
      tws_pkg::KIND_REMOVE: begin
        active[r.id] = 1'b0;
        e.status = tws_pkg::ST_REMOVED;
        expected_rsps.push_back(e);
      end
      tws_pkg::KIND_TICK: begin
        ticks = ticks + 32'd1;
        for (int i = 0; i < Timers; i++) begin
          lag = ticks - due_of[i];
          if (active[i] && slot_of[i] == wheel_ptr && !lag[31]) begin
            active[i] = 1'b0;
            expected_rsps.push_back('{status: tws_pkg::ST_EXPIRED, id: 5'(i), last: 1'b0});
          end
        end
        wheel_ptr = 6'((32'(wheel_ptr) + 32'd1) % Slots);
        e.status = tws_pkg::ST_DONE;
        expected_rsps.push_back(e);
      end
      default: ;
    endcase
  endfunction

  // driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (push && !full) begin
        predict_wheel('{kind: kind_i, id: timer_id_i, delay: delay_ms_i});
      end
      if (!push || !full) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          push <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          req_t r;
          r = pending_reqs.pop_front();
          push <= 1'b1;
          kind_i <= r.kind;
          timer_id_i <= r.id;
          delay_ms_i <= r.delay;
          if (!quiet && $urandom_range(0, 5) == 0) send_gap <= $urandom_range(1, 7);
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (rst_ni) begin
      if (pop && !empty) begin
        if (expected_rsps.size() == 0) begin
          $error("result with nothing expected: status %0d", status_o);
          errors = errors + 1;
        end else begin
          rsp_t e;
          e = expected_rsps.pop_front();
          if (status_o !== e.status) begin
            $error("status expected %0d got %0d", e.status, status_o);
            errors = errors + 1;
          end
          if (expired_id_o !== e.id) begin
            $error("expired_id expected %0d got %0d", e.id, expired_id_o);
            errors = errors + 1;
          end
          if (last_o !== e.last) begin
            $error("last expected %0d got %0d", e.last, last_o);
            errors = errors + 1;
          end
        end
      end
      if (hold_pop) begin
        pop <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
        if (!quiet && $urandom_range(0, 5) == 0) recv_gap <= $urandom_range(1, 7);
      end
    end
  end

  // receiver hold-off: stall the result side so the input backs up
  initial begin
    wait (phase == 1);
    hold_pop <= 1'b1;
    repeat (400) @(posedge clk_i);
    hold_pop <= 1'b0;
  end

  always @(posedge clk_i) begin
    if (cycles > CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic req_t mk(logic [1:0] k, logic [4:0] id, logic [23:0] d);
    return '{kind: k, id: id, delay: d};
  endfunction

  // random item of any kind; delays mostly reachable, some wide or negative
  function automatic req_t rand_item();
    logic [23:0] d;
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 4) d = 24'($urandom_range(0, 40 * 20));
    else if (sel < 6) d = 24'($urandom);
    else if (sel < 7) d = 24'h800000 | 24'($urandom);
    else d = 24'($urandom_range(0, 100));
    sel = $urandom_range(0, 19);
    if (sel < 8) return mk(tws_pkg::KIND_ADD, 5'($urandom), d);
    if (sel < 11) return mk(tws_pkg::KIND_REMOVE, 5'($urandom), 24'($urandom));
    if (sel < 19) return mk(tws_pkg::KIND_TICK, 5'($urandom), 24'($urandom));
    return mk(tws_pkg::KIND_NONE, 5'($urandom), 24'($urandom));
  endfunction

  task automatic drain_and_idle();
    wait (pending_reqs.size() == 0 && !push);
    wait (expected_rsps.size() == 0);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic write_period(logic [15:0] v);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    period_ms = v;
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    logic [15:0] periods[5];
    for (int i = 0; i < Timers; i++) begin
      active[i] = 1'b0;
      slot_of[i] = '0;
      due_of[i] = '0;
    end
    periods = '{16'd1, 16'd0, 16'd7, 16'hFFFF, 16'd10};
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: extremes, rejects, same slot expiry, exact and rounded delays
    pending_reqs.push_back(mk(tws_pkg::KIND_ADD, 5'd0, 24'd0));
    pending_reqs.push_back(mk(tws_pkg::KIND_ADD, 5'd0, 24'd5));
    pending_reqs.push_back(mk(tws_pkg::KIND_ADD, 5'd31, 24'd10));
    pending_reqs.push_back(mk(tws_pkg::KIND_ADD, 5'd1, 24'd15));
    pending_reqs.push_back(mk(tws_pkg::KIND_ADD, 5'd2, 24'h800000));
    pending_reqs.push_back(mk(tws_pkg::KIND_ADD, 5'd3, 24'h7FFFFF));
    pending_reqs.push_back(mk(tws_pkg::KIND_ADD, 5'd4, 24'hFFFFFF));
    pending_reqs.push_back(mk(tws_pkg::KIND_ADD, 5'd5, 24'd640));
    pending_reqs.push_back(mk(tws_pkg::KIND_NONE, 5'd5, 24'd1));
    pending_reqs.push_back(mk(tws_pkg::KIND_TICK, 5'd0, 24'd0));
    pending_reqs.push_back(mk(tws_pkg::KIND_TICK, 5'd0, 24'd0));
    pending_reqs.push_back(mk(tws_pkg::KIND_TICK, 5'd0, 24'd0));
    pending_reqs.push_back(mk(tws_pkg::KIND_REMOVE, 5'd3, 24'd0));
    pending_reqs.push_back(mk(tws_pkg::KIND_REMOVE, 5'd3, 24'd0));
    pending_reqs.push_back(mk(tws_pkg::KIND_REMOVE, 5'd31, 24'hFFFFFF));
    for (int i = 0; i < 8; i++) pending_reqs.push_back(mk(tws_pkg::KIND_TICK, 5'd0, 24'd0));
    drain_and_idle();

    for (int ph = 0; ph < 5; ph++) begin
      write_period(periods[ph]);
      phase = ph;
      if (ph == 4) quiet = 1'b1;
      for (int i = 0; i < 12; i++) pending_reqs.push_back(rand_item());
      // add every id at the current slot; one tick reports all those accepted
      if (ph == 2) begin
        for (int i = 0; i < Timers; i++) begin
          pending_reqs.push_back(mk(tws_pkg::KIND_ADD, 5'(i), 24'd0));
        end
        for (int i = 0; i < 2; i++) pending_reqs.push_back(mk(tws_pkg::KIND_TICK, 5'd0, 24'd0));
      end
      drain_and_idle();
    end

    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
